>>> hdl/free_list_block_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLBA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define FLBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed one cycle later");

`endif

>>> hdl/flba_pkg.sv
package flba_pkg;

    // Request kinds.
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_RANGE     = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 1'd1;

    // Field widths fixed by the interface.
    localparam int BASE_W  = 32;
    localparam int BYTES_W = 17;
    localparam int RIDX_W  = 8;
    localparam int GIDX_W  = 8;
    localparam int ADDR_W  = 48;
    localparam int MARK_W  = 9;

    // Outcome of one allocate or release step.
    typedef struct packed {
        t_status status;
        logic    grant;
    } t_step_rsp;

endpackage

>>> hdl/flba_link_ram.sv
module flba_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // One write port for pushes.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One registered read port for the link prefetch.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/flba_alloc_state.sv
module flba_alloc_state #(
    parameter int POOL_BLOCKS = 256,
    parameter int IW          = 8,
    parameter int CW          = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic                      i_kind,
    input  logic [flba_pkg::RIDX_W-1:0] i_rel_index,
    output flba_pkg::t_step_rsp       o_rsp,
    output logic [IW-1:0]             o_idx,
    output logic [CW-1:0]             o_mark_next,
    output logic [CW-1:0]             o_mark,
    output logic [CW-1:0]             o_bump
);

    // Common width for comparing the release index against counts.
    localparam int WW = (CW > flba_pkg::RIDX_W) ? CW : flba_pkg::RIDX_W;
    localparam int LW = IW + 1;

    logic          r_head_valid;
    logic [IW-1:0] r_head;
    logic [LW-1:0] r_head_next;
    logic          r_hn_from_mem;
    logic [CW-1:0] r_bump;
    logic [CW-1:0] r_mark;

    logic          n_head_valid;
    logic [IW-1:0] n_head;
    logic [LW-1:0] n_head_next;
    logic          n_hn_from_mem;
    logic [CW-1:0] n_bump;
    logic [CW-1:0] n_mark;

    logic [LW-1:0] w_hn;
    logic [LW-1:0] w_rdata;
    logic          w_we;
    logic          w_re;
    logic [IW-1:0] w_rel;
    logic [WW-1:0] w_rel_ext;

    // The link of the current head is either the prefetched read or a register.
    assign w_hn      = r_hn_from_mem ? w_rdata : r_head_next;
    assign w_rel     = IW'(i_rel_index);
    assign w_rel_ext = WW'(i_rel_index);

    // Decide the step and the next state.
    always_comb begin
        n_head_valid  = r_head_valid;
        n_head        = r_head;
        n_head_next   = r_head_next;
        n_hn_from_mem = r_hn_from_mem;
        n_bump        = r_bump;
        n_mark        = r_mark;
        o_rsp.status  = flba_pkg::ST_OK;
        o_rsp.grant   = 1'b0;
        o_idx         = '0;
        w_we          = 1'b0;
        w_re          = 1'b0;
        if (i_kind == flba_pkg::KIND_ALLOC) begin
            if (r_head_valid) begin
                // Pop the free list and prefetch the link of the new head.
                o_rsp.grant   = 1'b1;
                o_idx         = r_head;
                n_head_valid  = w_hn[IW];
                n_head        = w_hn[IW-1:0];
                n_hn_from_mem = 1'b1;
                w_re          = i_go;
            end else if (r_bump < CW'(POOL_BLOCKS)) begin
                // Hand out a never-used block.
                o_rsp.grant = 1'b1;
                o_idx       = IW'(r_bump);
                n_bump      = r_bump + CW'(1);
                n_mark      = r_mark + CW'(1);
            end else begin
                o_rsp.status = flba_pkg::ST_EXHAUSTED;
            end
        end else begin
            if (w_rel_ext >= WW'(r_bump)) begin
                o_rsp.status = flba_pkg::ST_RANGE;
            end else begin
                // Push the block and lower the mark if it sat just below it.
                if (r_mark != '0 && (w_rel_ext + WW'(1)) == WW'(r_mark)) begin
                    n_mark = r_mark - CW'(1);
                end
                w_we          = i_go;
                n_head_next   = {r_head_valid, r_head};
                n_hn_from_mem = 1'b0;
                n_head        = w_rel;
                n_head_valid  = 1'b1;
            end
        end
    end

    // State registers move only when a step executes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid  <= 1'b0;
            r_hn_from_mem <= 1'b0;
            r_bump        <= '0;
            r_mark        <= '0;
        end else if (i_go) begin
            r_head_valid  <= n_head_valid;
            r_hn_from_mem <= n_hn_from_mem;
            r_bump        <= n_bump;
            r_mark        <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_head      <= n_head;
            r_head_next <= n_head_next;
        end
    end

    flba_link_ram #(
        .DEPTH(POOL_BLOCKS),
        .AW   (IW),
        .DW   (LW)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_rel),
        .i_wdata({r_head_valid, r_head}),
        .i_re   (w_re),
        .i_raddr(w_hn[IW-1:0]),
        .o_rdata(w_rdata)
    );

    assign o_mark_next = n_mark;
    assign o_mark      = r_mark;
    assign o_bump      = r_bump;

endmodule

>>> hdl/free_list_block_allocator_core.sv
// A request is held in the input register, and its result is registered in the result register.
// Throughput: one allocate or release per cycle while the result side is not stalled, set by the head pop
// that uses the prefetched link of the head and one link RAM write per push.
// Reset (synchronous, active low) empties the free list, clears the bump count and
// the mark, and loads base address 0 and block size 64; link RAM is not cleared.
`include "free_list_block_allocator_core_defines.svh"

module free_list_block_allocator_core #(
    parameter int POOL_BLOCKS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [flba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [flba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [flba_pkg::RIDX_W-1:0]       i_release_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [flba_pkg::GIDX_W-1:0]       o_granted_index,
    output logic [flba_pkg::ADDR_W-1:0]       o_granted_address,
    output logic [flba_pkg::MARK_W-1:0]       o_occupied_mark
);

    localparam int IW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int CW = $clog2(POOL_BLOCKS + 1);
    localparam int PW = IW + flba_pkg::BYTES_W;

    logic [flba_pkg::BASE_W-1:0]  r_base;
    logic [flba_pkg::BYTES_W-1:0] r_block_bytes;

    logic                         r_s1_valid;
    logic                         r_s1_kind;
    logic [flba_pkg::RIDX_W-1:0]  r_s1_index;

    logic                         r_out_valid;
    flba_pkg::t_status            r_status;
    logic [flba_pkg::GIDX_W-1:0]  r_gidx;
    logic [flba_pkg::ADDR_W-1:0]  r_gaddr;
    logic [flba_pkg::MARK_W-1:0]  r_mark_out;

    logic                         w_s1_load;
    logic                         w_s2_load;
    logic                         w_go;
    flba_pkg::t_step_rsp          w_rsp;
    logic [IW-1:0]                w_idx;
    logic [CW-1:0]                w_mark_next;
    logic [CW-1:0]                w_mark;
    logic [CW-1:0]                w_bump;
    logic [PW-1:0]                w_prod;
    logic [flba_pkg::ADDR_W-1:0]  w_gaddr;
    logic                         w_exhaust;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base        <= '0;
            r_block_bytes <= flba_pkg::BYTES_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                flba_pkg::CFG_BASE:  r_base        <= i_cfg_data;
                flba_pkg::CFG_BYTES: r_block_bytes <= i_cfg_data[flba_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: the result register frees up when it is empty or taken.
    assign w_s2_load  = !r_out_valid || !i_out_stall;
    assign w_s1_load  = !r_s1_valid || w_s2_load;
    assign o_in_stall = !w_s1_load;
    assign w_go       = r_s1_valid && w_s2_load;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_in_valid) begin
            r_s1_kind  <= i_kind;
            r_s1_index <= i_release_index;
        end
    end

    flba_alloc_state #(
        .POOL_BLOCKS(POOL_BLOCKS),
        .IW         (IW),
        .CW         (CW)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_kind     (r_s1_kind),
        .i_rel_index(r_s1_index),
        .o_rsp      (w_rsp),
        .o_idx      (w_idx),
        .o_mark_next(w_mark_next),
        .o_mark     (w_mark),
        .o_bump     (w_bump)
    );

    // Byte address of the granted block.
    assign w_prod  = PW'(w_idx) * PW'(r_block_bytes);
    assign w_gaddr = flba_pkg::ADDR_W'(r_base) + flba_pkg::ADDR_W'(w_prod);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_status   <= w_rsp.status;
            r_gidx     <= w_rsp.grant ? flba_pkg::GIDX_W'(w_idx) : '0;
            r_gaddr    <= w_rsp.grant ? w_gaddr : '0;
            r_mark_out <= flba_pkg::MARK_W'(w_mark_next);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_index   = r_gidx;
    assign o_granted_address = r_gaddr;
    assign o_occupied_mark   = r_mark_out;

    assign w_exhaust = w_go && (w_rsp.status == flba_pkg::ST_EXHAUSTED);

    // The mark never passes the number of blocks ever handed out.
    `FLBA_ASSERT_SAME(a_mark_le_bump, 1'b1, w_mark <= w_bump)
    // Exhaustion is reported only when the bump counter is spent.
    `FLBA_ASSERT_SAME(a_exhaust_full, w_exhaust, w_bump == CW'(POOL_BLOCKS))
    // A full input register behind a stalled result holds off new transactions.
    `FLBA_ASSERT_SAME(a_backpressure, r_s1_valid && r_out_valid && i_out_stall, o_in_stall)
    // An executed step always shows up in the result register next cycle.
    `FLBA_ASSERT_NEXT(a_step_to_out, w_go, r_out_valid)

endmodule

>>> sim/flba_checker.sv
module flba_checker #(
    parameter int POOL_BLOCKS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [flba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [flba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_kind,
    input  logic [flba_pkg::RIDX_W-1:0]       i_release_index,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [1:0]                        i_status,
    input  logic [flba_pkg::GIDX_W-1:0]       i_granted_index,
    input  logic [flba_pkg::ADDR_W-1:0]       i_granted_address,
    input  logic [flba_pkg::MARK_W-1:0]       i_occupied_mark,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_free_len,
    output logic [flba_pkg::MARK_W-1:0]       o_bump_count,
    output logic [flba_pkg::MARK_W-1:0]       o_mark,
    output logic [POOL_BLOCKS-1:0]            o_held
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted allocator response.
    typedef struct packed {
        flba_pkg::t_status                 status;
        logic [flba_pkg::GIDX_W-1:0]       index;
        logic [flba_pkg::ADDR_W-1:0]       address;
        logic [flba_pkg::MARK_W-1:0]       mark;
    } t_alloc_result;

    t_alloc_result        alloc_result_q[$];

    // Shadow copy of the configuration and the free list.
    logic [flba_pkg::BASE_W-1:0]    base_addr;
    logic [flba_pkg::BYTES_W-1:0]   blk_bytes;
    logic                           head_valid;
    logic [flba_pkg::GIDX_W-1:0]    head;
    logic [flba_pkg::GIDX_W-1:0]    link [POOL_BLOCKS];
    logic                           link_valid [POOL_BLOCKS];
    int                             fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] allocator %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fails++;
    endtask

    task automatic clear_shadow();
        base_addr = '0;
        blk_bytes = flba_pkg::BYTES_W'(64);
        head_valid = 1'b0;
        head = '0;
        for (int k = 0; k < POOL_BLOCKS; k++) begin
            link[k] = '0;
            link_valid[k] = 1'b0;
        end
        o_bump_count = '0;
        o_mark = '0;
        o_free_len = 0;
        o_held = '0;
        alloc_result_q.delete();
    endtask

    // Work out the response of one allocate or release transaction.
    task automatic predict_alloc(input logic kind, input logic [flba_pkg::RIDX_W-1:0] ridx);
        t_alloc_result res;
        logic          grant;
        logic [flba_pkg::GIDX_W-1:0] idx;
        res = '0;
        grant = 1'b0;
        idx = '0;
        if (kind == flba_pkg::KIND_ALLOC) begin
            if (head_valid) begin
                // Pop the most recently released block.
                idx = head;
                head_valid = link_valid[idx];
                head = link[idx];
                o_free_len--;
                grant = 1'b1;
            end else if (o_bump_count < POOL_BLOCKS) begin
                // Take a never-used block and raise the mark.
                idx = o_bump_count[flba_pkg::GIDX_W-1:0];
                o_bump_count++;
                o_mark++;
                grant = 1'b1;
            end else begin
                res.status = flba_pkg::ST_EXHAUSTED;
            end
            if (grant) begin
                res.index = idx;
                res.address = flba_pkg::ADDR_W'(base_addr)
                            + flba_pkg::ADDR_W'(idx) * flba_pkg::ADDR_W'(blk_bytes);
                o_held[idx] = 1'b1;
            end
        end else if (ridx >= o_bump_count) begin
            res.status = flba_pkg::ST_RANGE;
        end else begin
            // Push onto the list head; lower the mark if this is the top block.
            if (o_mark != 0 && ridx == o_mark - 1) begin
                o_mark--;
            end
            link[ridx] = head;
            link_valid[ridx] = head_valid;
            head = ridx;
            head_valid = 1'b1;
            o_free_len++;
            o_held[ridx] = 1'b0;
        end
        res.mark = o_mark;
        alloc_result_q.push_back(res);
    endtask

    task automatic check_alloc_result();
        t_alloc_result want;
        if (alloc_result_q.size() == 0) begin
            report_mismatch("response with nothing outstanding, status", i_status, '0);
            return;
        end
        want = alloc_result_q.pop_front();
        if (i_status !== want.status) begin
            report_mismatch("status", i_status, want.status);
        end
        if (i_granted_index !== want.index) begin
            report_mismatch("granted index", i_granted_index, want.index);
        end
        if (i_granted_address !== want.address) begin
            report_mismatch("granted address", i_granted_address, want.address);
        end
        if (i_occupied_mark !== want.mark) begin
            report_mismatch("occupied mark", i_occupied_mark, want.mark);
        end
    endtask

    // Responses are checked before the same edge's request is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_shadow();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_alloc_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    flba_pkg::CFG_BASE: begin
                        base_addr = i_cfg_data[flba_pkg::BASE_W-1:0];
                    end
                    flba_pkg::CFG_BYTES: begin
                        blk_bytes = i_cfg_data[flba_pkg::BYTES_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_alloc(i_kind, i_release_index);
            end
        end
        o_pending = alloc_result_q.size();
    end

endmodule

>>> sim/tb_free_list_block_allocator_core.sv
module tb_free_list_block_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_BLOCKS = 256;
    localparam int HOLD_CYCLES = 80;

    typedef enum {PICK_GIVEN, PICK_HELD, PICK_ANY} t_pick;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [flba_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [flba_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                              i_in_valid = 1'b0;
    logic                              i_kind = 1'b0;
    logic [flba_pkg::RIDX_W-1:0]       i_release_index = '0;
    logic                              i_out_stall = 1'b0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic [1:0]                        o_status;
    logic [flba_pkg::GIDX_W-1:0]       o_granted_index;
    logic [flba_pkg::ADDR_W-1:0]       o_granted_address;
    logic [flba_pkg::MARK_W-1:0]       o_occupied_mark;

    int                                fail_count;
    int                                pending;
    int                                free_len;
    logic [flba_pkg::MARK_W-1:0]       bump_seen;
    logic [flba_pkg::MARK_W-1:0]       mark_seen;
    logic [POOL_BLOCKS-1:0]            held_map;

    int                                sender_idle_pct = 27;
    int                                recv_stall_pct = 51;
    int                                hold_req = 0;
    int                                hold_taken = 0;
    int                                hold_left = 0;
    logic [flba_pkg::RIDX_W-1:0]       last_index;

    free_list_block_allocator_core #(
        .POOL_BLOCKS(POOL_BLOCKS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_release_index(i_release_index),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_granted_index(o_granted_index),
        .o_granted_address(o_granted_address),
        .o_occupied_mark(o_occupied_mark)
    );

    flba_checker #(
        .POOL_BLOCKS(POOL_BLOCKS)
    ) u_alloc_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_release_index(i_release_index),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status(o_status),
        .i_granted_index(o_granted_index),
        .i_granted_address(o_granted_address),
        .i_occupied_mark(o_occupied_mark),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_free_len(free_len),
        .o_bump_count(bump_seen),
        .o_mark(mark_seen),
        .o_held(held_map)
    );

    always #1 i_clk = ~i_clk;

    // Response side: random stall, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Pick a block that is currently handed out, favoring the one under the mark.
    function automatic bit pick_held(output logic [flba_pkg::RIDX_W-1:0] idx);
        int start;
        idx = '0;
        if (mark_seen != 0 && held_map[mark_seen - 1] && $urandom_range(0, 1) == 1) begin
            idx = flba_pkg::RIDX_W'(mark_seen - 1);
            return 1'b1;
        end
        start = $urandom_range(0, POOL_BLOCKS - 1);
        for (int k = 0; k < POOL_BLOCKS; k++) begin
            if (held_map[(start + k) % POOL_BLOCKS]) begin
                idx = flba_pkg::RIDX_W'((start + k) % POOL_BLOCKS);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Offer one transaction and wait until it is accepted.
    task automatic send_req(input logic kind, input t_pick pick,
                            input logic [flba_pkg::RIDX_W-1:0] given);
        logic                        k;
        logic [flba_pkg::RIDX_W-1:0] ridx;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        k = kind;
        ridx = given;
        if (pick == PICK_ANY) begin
            ridx = flba_pkg::RIDX_W'($urandom_range(0, 255));
        end else if (pick == PICK_HELD && kind == flba_pkg::KIND_RELEASE
                     && !pick_held(ridx)) begin
            // Nothing is handed out, so allocate instead.
            k = flba_pkg::KIND_ALLOC;
            ridx = flba_pkg::RIDX_W'($urandom_range(0, 255));
        end
        i_in_valid <= 1'b1;
        i_kind <= k;
        i_release_index <= ridx;
        last_index = ridx;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [flba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [flba_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Bursts of allocations and releases of held blocks, with optional noise.
    task automatic run_traffic(input int n_items, input bit noisy);
        int done_items;
        int burst;
        int roll;
        done_items = 0;
        while (done_items < n_items) begin
            roll = $urandom_range(0, 99);
            burst = $urandom_range(1, 16);
            if (noisy && roll < 12) begin
                send_req(1'($urandom_range(0, 1)), PICK_ANY, '0);
                burst = 1;
            end else if (roll < 56) begin
                repeat (burst) send_req(flba_pkg::KIND_ALLOC, PICK_ANY, '0);
            end else begin
                repeat (burst) send_req(flba_pkg::KIND_RELEASE, PICK_HELD, '0);
            end
            done_items += burst;
        end
    endtask

    // Allocate until the free list and the never-used blocks are gone, then past that.
    task automatic fill_pool();
        int need;
        go_idle();
        need = free_len + POOL_BLOCKS - int'(bump_seen) + 3;
        repeat (need) send_req(flba_pkg::KIND_ALLOC, PICK_ANY, '0);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration.
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd0);     // nothing handed out yet
        send_req(flba_pkg::KIND_ALLOC, PICK_GIVEN, 8'd0);
        send_req(flba_pkg::KIND_ALLOC, PICK_GIVEN, 8'hFF);      // index ignored on allocate
        send_req(flba_pkg::KIND_ALLOC, PICK_GIVEN, 8'h5A);
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd255);   // top of the index range
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd3);     // equal to the bump count
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd2);     // block under the mark
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd0);
        send_req(flba_pkg::KIND_ALLOC, PICK_GIVEN, 8'hA5);      // pops from the list
        send_req(flba_pkg::KIND_ALLOC, PICK_GIVEN, 8'h00);
        send_req(flba_pkg::KIND_ALLOC, PICK_GIVEN, 8'hFF);      // list empty again, bump
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd1);
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd2);
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd3);
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, 8'd0);
        send_req(flba_pkg::KIND_ALLOC, PICK_GIVEN, 8'hFF);
        wait_drained();

        // Largest base and a block size of 0x10000 bytes; fill the pool to exhaustion at the end.
        write_reg(flba_pkg::CFG_BASE, 32'hFFFF_FFFF);
        write_reg(flba_pkg::CFG_BYTES, 32'h0001_0000);
        run_traffic(300, 1'b0);
        fill_pool();
        wait_drained();

        // Base 0 and block size 8, idling swapped.
        sender_idle_pct = 51;
        recv_stall_pct = 27;
        write_reg(flba_pkg::CFG_BASE, '0);
        write_reg(flba_pkg::CFG_BYTES, 32'd8);
        run_traffic(550, 1'b0);
        wait_drained();

        // Random settings, no idling; a long hold-off backs the block up.
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(flba_pkg::CFG_BASE, $urandom());
        write_reg(flba_pkg::CFG_BYTES, flba_pkg::CFG_DATA_W'($urandom_range(8, 65536)));
        hold_req++;
        run_traffic(200, 1'b0);
        wait_drained();

        // Release the same block twice; it goes back on the list both times.
        send_req(flba_pkg::KIND_RELEASE, PICK_HELD, '0);
        send_req(flba_pkg::KIND_RELEASE, PICK_GIVEN, last_index);
        run_traffic(350, 1'b1);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
